// ===== rtl/nbls_pkg.sv =====
// Package for the NAT balancer / learning switch: sizes, codes and item types.
// No dependencies.
package nbls_pkg;

  localparam int unsigned ConnEntries = 512;
  localparam int unsigned MacEntries  = 256;
  localparam int unsigned ConnAw      = $clog2(ConnEntries);
  localparam int unsigned MacAw       = $clog2(MacEntries);

  localparam logic [15:0] EtArp  = 16'h0608;
  localparam logic [15:0] EtIpv4 = 16'h0008;

  localparam logic [1:0] RegServerCount = 2'd0;
  localparam logic [1:0] RegServerOne   = 2'd1;
  localparam logic [1:0] RegServerTwo   = 2'd2;

  typedef struct packed {
    logic [15:0] ethertype;
    logic [47:0] source_mac;
    logic [47:0] dest_mac;
    logic [7:0]  arrival_port;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] checksum_in;
  } item_in_t;

  typedef struct packed {
    logic [31:0] src_addr_out;
    logic [31:0] dst_addr_out;
    logic [15:0] checksum_out;
    logic [7:0]  egress_port;
    logic        flood;
  } item_out_t;

  typedef struct packed {
    logic [1:0] reg_index;
    logic [31:0] data;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLASSIFY, ST_CONN_SCAN, ST_CONN_WRITE, ST_MAC_SCAN, ST_MAC_WRITE,
    ST_FWD_SCAN, ST_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic classify;
    logic conn_clr;
    logic conn_step;
    logic conn_write;
    logic mac_clr;
    logic mac_step;
    logic mac_write;
    logic fwd_clr;
    logic fwd_step;
    logic finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic conn_needed;
    logic conn_done;
    logic mac_needed;
    logic mac_done;
    logic fwd_done;
  } status_t;

endpackage

// ===== rtl/nbls_if.sv =====
// Valid/ready channel interfaces for items and configuration writes.
// Depends on nbls_pkg.
interface nbls_in_if;
  logic valid;
  logic ready;
  nbls_pkg::item_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface nbls_out_if;
  logic valid;
  logic ready;
  nbls_pkg::item_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface nbls_cfg_if;
  logic valid;
  logic ready;
  nbls_pkg::cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/nbls_ctrl.sv =====
// Controller FSM: sequences classify, table scans and table writes per item.
// Depends on nbls_pkg.
module nbls_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  nbls_pkg::status_t   status_i,
  output nbls_pkg::cmd_t      cmd_o
);
  nbls_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nbls_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      nbls_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = nbls_pkg::ST_CLASSIFY;
        end
      end
      nbls_pkg::ST_CLASSIFY: begin
        cmd_o.classify = 1'b1;
        cmd_o.conn_clr = 1'b1;
        state_d        = nbls_pkg::ST_CONN_SCAN;
      end
      nbls_pkg::ST_CONN_SCAN: begin
        if (status_i.conn_done) begin
          state_d = status_i.conn_needed ? nbls_pkg::ST_CONN_WRITE : nbls_pkg::ST_MAC_SCAN;
          cmd_o.mac_clr = !status_i.conn_needed;
        end else begin
          cmd_o.conn_step = 1'b1;
        end
      end
      nbls_pkg::ST_CONN_WRITE: begin
        cmd_o.conn_write = 1'b1;
        cmd_o.mac_clr    = 1'b1;
        state_d          = nbls_pkg::ST_MAC_SCAN;
      end
      nbls_pkg::ST_MAC_SCAN: begin
        if (status_i.mac_done) begin
          state_d = status_i.mac_needed ? nbls_pkg::ST_MAC_WRITE : nbls_pkg::ST_FWD_SCAN;
          cmd_o.fwd_clr = !status_i.mac_needed;
        end else begin
          cmd_o.mac_step = 1'b1;
        end
      end
      nbls_pkg::ST_MAC_WRITE: begin
        cmd_o.mac_write = 1'b1;
        cmd_o.fwd_clr   = 1'b1;
        state_d         = nbls_pkg::ST_FWD_SCAN;
      end
      nbls_pkg::ST_FWD_SCAN: begin
        if (status_i.fwd_done) begin
          state_d = nbls_pkg::ST_OUT;
        end else begin
          cmd_o.fwd_step = 1'b1;
        end
      end
      nbls_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = nbls_pkg::ST_IDLE;
        end
      end
      default: state_d = nbls_pkg::ST_IDLE;
    endcase
  end
endmodule

// ===== rtl/nbls_datapath.sv =====
// Datapath: config registers, NAT rewrite, connection and MAC tables, result register.
// Depends on nbls_pkg. Tables are scanned one entry per cycle.
module nbls_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  nbls_pkg::cfg_t         cfg_i,
  input  nbls_pkg::item_in_t     item_i,
  input  nbls_pkg::cmd_t         cmd_i,
  output nbls_pkg::status_t      status_o,
  output nbls_pkg::item_out_t    result_o
);
  localparam int unsigned CAw = nbls_pkg::ConnAw;
  localparam int unsigned MAw = nbls_pkg::MacAw;

  logic [1:0]  srv_cnt_q;
  logic [31:0] srv_one_q, srv_two_q;

  nbls_pkg::item_in_t it_q;
  logic [31:0] nsrc_q, ndst_q, ck_q;
  logic        inb_q, outb_q;

  // connection entries fill from index 0 and are never removed
  logic [CAw:0] conn_fill_q;
  logic [31:0] conn_key_mem [nbls_pkg::ConnEntries];
  logic [63:0] conn_pair_mem [nbls_pkg::ConnEntries];
  logic [nbls_pkg::MacEntries-1:0] mac_valid_q;
  logic [47:0] mac_key_mem [nbls_pkg::MacEntries];
  logic [7:0]  mac_port_mem [nbls_pkg::MacEntries];

  logic [CAw:0] cidx_q;
  logic [CAw-1:0] chit_q, cfree_q;
  logic chit_f_q, cfree_f_q;
  logic [MAw:0] midx_q;
  logic [MAw-1:0] mhit_q, mfree_q;
  logic mhit_f_q, mfree_f_q;
  logic fhit_q;
  logic [7:0] fport_q;

  logic [31:0] ckey_rd;
  logic [63:0] cpair_rd;
  logic [47:0] mkey_rd;
  logic [7:0]  mport_rd;
  logic [CAw-1:0] cptr;
  logic [MAw-1:0] mptr;

  // read data is registered: crd_q tracks entry of ckey_rd
  logic [CAw:0] crd_q;
  logic [MAw:0] mrd_q;
  logic crd_v_q, mrd_v_q;

  logic [31:0] conn_pair_mem_hi, conn_pair_mem_lo;
  logic [63:0] hit_pair_q;

  assign cptr = cidx_q[CAw-1:0];
  assign mptr = midx_q[MAw-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srv_cnt_q <= '0;
      srv_one_q <= '0;
      srv_two_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_i.reg_index)
        nbls_pkg::RegServerCount: srv_cnt_q <= cfg_i.data[1:0];
        nbls_pkg::RegServerOne:   srv_one_q <= cfg_i.data;
        nbls_pkg::RegServerTwo:   srv_two_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // classification
  logic [1:0] live;
  logic arp_ip, is_ip, dsv, ssv, key_ok;
  logic [31:0] srv, ck;
  logic [15:0] a, b, c;
  always_comb begin
    live   = (srv_cnt_q > 2'd2) ? 2'd2 : srv_cnt_q;
    arp_ip = (it_q.ethertype == nbls_pkg::EtArp) || (it_q.ethertype == nbls_pkg::EtIpv4);
    is_ip  = it_q.ethertype == nbls_pkg::EtIpv4;
    dsv = ((live >= 2'd1) && srv_one_q == it_q.dst_addr) ||
          ((live >= 2'd2) && srv_two_q == it_q.dst_addr);
    ssv = ((live >= 2'd1) && srv_one_q == it_q.src_addr) ||
          ((live >= 2'd2) && srv_two_q == it_q.src_addr);
    key_ok = it_q.src_addr[16] ? (live >= 2'd2) : (live >= 2'd1);
    srv = it_q.src_addr[16] ? srv_two_q : srv_one_q;
    a = it_q.src_addr[31:16];
    b = it_q.dst_addr[31:16];
    c = srv[31:16];
    ck = 32'd7 * ((32'(a) * 32'd3) + (32'(b) * 32'd7) + (32'(c) * 32'd13));
  end

  assign conn_pair_mem_hi = hit_pair_q[63:32];
  assign conn_pair_mem_lo = hit_pair_q[31:0];

  logic [31:0] nsrc_f, ndst_f;
  logic [15:0] ncs_f;
  logic [31:0] nc;
  always_comb begin
    nsrc_f = nsrc_q;
    ndst_f = ndst_q;
    if (outb_q && chit_f_q) begin
      ndst_f = conn_pair_mem_hi;
      nsrc_f = conn_pair_mem_lo;
    end
    nc = 32'(it_q.checksum_in)
       + (32'(it_q.dst_addr[15:0]) - 32'(ndst_f[15:0]))
       + (32'(it_q.dst_addr[31:16]) - 32'(ndst_f[31:16]))
       + (32'(it_q.src_addr[15:0]) - 32'(nsrc_f[15:0]))
       + (32'(it_q.src_addr[31:16]) - 32'(nsrc_f[31:16]));
    ncs_f = it_q.checksum_in;
    if (arp_ip && is_ip && (nsrc_f != it_q.src_addr || ndst_f != it_q.dst_addr))
      ncs_f = nc[15:0] + nc[31:16];
  end

  logic [31:0] ckey_cmp;
  assign ckey_cmp = inb_q ? ck_q : it_q.dst_addr;

  always_ff @(posedge clk_i) begin
    ckey_rd  <= conn_key_mem[cptr];
    cpair_rd <= conn_pair_mem[cptr];
    mkey_rd  <= mac_key_mem[mptr];
    mport_rd <= mac_port_mem[mptr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) it_q <= item_i;
    if (cmd_i.classify) begin
      ck_q <= ck;
      if (arp_ip && dsv && !ssv && key_ok) begin
        nsrc_q <= ck;
        ndst_q <= srv;
      end else begin
        nsrc_q <= it_q.src_addr;
        ndst_q <= it_q.dst_addr;
      end
    end
    if (cmd_i.classify) hit_pair_q <= '0;
    else if (cmd_i.conn_step && crd_v_q && !chit_f_q && (crd_q < conn_fill_q) &&
             ckey_rd == ckey_cmp)
      hit_pair_q <= cpair_rd;
    if (cmd_i.finish) begin
      result_o.src_addr_out <= nsrc_f;
      result_o.dst_addr_out <= ndst_f;
      result_o.checksum_out <= ncs_f;
      result_o.egress_port  <= fhit_q ? fport_q : 8'd0;
      result_o.flood        <= !fhit_q;
    end
    if (cmd_i.conn_write) begin
      conn_pair_mem[chit_f_q ? chit_q : cfree_q] <= {it_q.src_addr, it_q.dst_addr};
      if (!chit_f_q) conn_key_mem[cfree_q] <= ck_q;
    end
    if (cmd_i.mac_write) begin
      mac_port_mem[mhit_f_q ? mhit_q : mfree_q] <= it_q.arrival_port;
      if (!mhit_f_q) mac_key_mem[mfree_q] <= it_q.source_mac;
    end
  end

  logic conn_need_c, mac_need_c;
  assign conn_need_c = inb_q && (chit_f_q || cfree_f_q);
  assign mac_need_c  = !it_q.source_mac[0] && (mhit_f_q || mfree_f_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conn_fill_q  <= '0;
      mac_valid_q  <= '0;
      inb_q <= 1'b0; outb_q <= 1'b0;
      cidx_q <= '0; crd_q <= '0; crd_v_q <= 1'b0;
      chit_f_q <= 1'b0; cfree_f_q <= 1'b0; chit_q <= '0; cfree_q <= '0;
      midx_q <= '0; mrd_q <= '0; mrd_v_q <= 1'b0;
      mhit_f_q <= 1'b0; mfree_f_q <= 1'b0; mhit_q <= '0; mfree_q <= '0;
      fhit_q <= 1'b0; fport_q <= '0;
    end else begin
      if (cmd_i.classify) begin
        inb_q  <= arp_ip && dsv && !ssv && key_ok;
        outb_q <= arp_ip && ssv && !dsv;
      end
      if (cmd_i.conn_clr) begin
        cidx_q <= '0; crd_v_q <= 1'b0; chit_f_q <= 1'b0; cfree_f_q <= 1'b0;
      end else if (cmd_i.conn_step) begin
        crd_q   <= cidx_q;
        crd_v_q <= !cidx_q[CAw];
        if (!cidx_q[CAw]) cidx_q <= cidx_q + (CAw+1)'(1);
        if (crd_v_q) begin
          if (!chit_f_q && (crd_q < conn_fill_q) && ckey_rd == ckey_cmp) begin
            chit_f_q <= 1'b1; chit_q <= crd_q[CAw-1:0];
          end
          if (!cfree_f_q && (crd_q >= conn_fill_q)) begin
            cfree_f_q <= 1'b1; cfree_q <= crd_q[CAw-1:0];
          end
        end
      end
      if (cmd_i.conn_write && !chit_f_q) conn_fill_q <= conn_fill_q + (CAw+1)'(1);
      if (cmd_i.mac_clr || cmd_i.fwd_clr) begin
        midx_q <= '0; mrd_v_q <= 1'b0;
      end
      if (cmd_i.mac_clr) begin
        mhit_f_q <= 1'b0; mfree_f_q <= 1'b0;
      end
      if (cmd_i.fwd_clr) fhit_q <= 1'b0;
      if (cmd_i.mac_step || cmd_i.fwd_step) begin
        mrd_q   <= midx_q;
        mrd_v_q <= !midx_q[MAw];
        if (!midx_q[MAw]) midx_q <= midx_q + (MAw+1)'(1);
      end
      if (cmd_i.mac_step && mrd_v_q) begin
        if (!mhit_f_q && mac_valid_q[mrd_q[MAw-1:0]] && mkey_rd == it_q.source_mac) begin
          mhit_f_q <= 1'b1; mhit_q <= mrd_q[MAw-1:0];
        end
        if (!mfree_f_q && !mac_valid_q[mrd_q[MAw-1:0]]) begin
          mfree_f_q <= 1'b1; mfree_q <= mrd_q[MAw-1:0];
        end
      end
      if (cmd_i.fwd_step && mrd_v_q && !fhit_q && !it_q.dest_mac[0] &&
          mac_valid_q[mrd_q[MAw-1:0]] && mkey_rd == it_q.dest_mac) begin
        fhit_q <= 1'b1; fport_q <= mport_rd;
      end
      if (cmd_i.mac_write && !mhit_f_q) mac_valid_q[mfree_q] <= 1'b1;
    end
  end

  always_comb begin
    status_o.conn_needed = conn_need_c;
    status_o.conn_done   = !(inb_q || outb_q) || (cidx_q[CAw] && !crd_v_q);
    status_o.mac_needed  = mac_need_c;
    status_o.mac_done    = it_q.source_mac[0] || (midx_q[MAw] && !mrd_v_q);
    status_o.fwd_done    = it_q.dest_mac[0] || (midx_q[MAw] && !mrd_v_q);
  end
endmodule

// ===== rtl/nat_balancer_learning_switch.sv =====
// Top level of the NAT load balancer with MAC learning switch.
// Depends on nbls_pkg, nbls_if, nbls_ctrl and nbls_datapath.
//
// Usage: one parsed header enters per item on in_ch, one result leaves per
// item on out_ch; both are valid/ready channels. cfg_ch writes the server
// count (index 0) and the two server addresses (indexes 1 and 2); write it
// only while no item is in flight.
// Timing: one item at a time. The connection table is scanned when a rewrite
// or restore is attempted, the MAC table is scanned to learn a unicast source
// and scanned again to forward to a unicast destination, plus up to two table
// writes and the control states. These scans, one entry a cycle, set the time
// from one accept to the next.
// Reset clears the state machine, config registers, the connection fill
// count and the MAC valid bits at once; no clearing pass is needed. A stalled
// receiver holds the result in the output register; the next item is taken
// meanwhile and its result waits until the register frees.
module nat_balancer_learning_switch (
  input  logic          clk_i,
  input  logic          rst_ni,
  nbls_in_if.sink       in_ch,
  nbls_out_if.source    out_ch,
  nbls_cfg_if.sink      cfg_ch
);
  nbls_pkg::cmd_t    cmd;
  nbls_pkg::status_t status;

  assign cfg_ch.ready = 1'b1;

  nbls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  nbls_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_we_i (cfg_ch.valid),
    .cfg_i    (cfg_ch.data),
    .item_i   (in_ch.data),
    .cmd_i    (cmd),
    .status_o (status),
    .result_o (out_ch.data)
  );
endmodule
